[sv/ccd_pkg.sv]
// ----------------------------------------------------------------------------
// ccd_pkg
// Shared widths, transaction types and helpers for the circle collision
// depth pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package ccd_pkg;

  localparam int CW   = 32;
  localparam int RW   = CW - 1;
  localparam int PW   = 2 * CW;
  localparam int SW   = 2 * CW + 1;
  localparam int NW   = 3 * CW + 1;
  localparam int RTW  = CW + 1;
  localparam int SQW  = 2 * RTW;
  localparam int REMW = RTW + 2;

  typedef struct packed {
    logic                 func;
    logic signed [CW-1:0] center_x;
    logic signed [CW-1:0] center_y;
    logic [RW-1:0]        radius;
    logic signed [CW-1:0] first_x;
    logic signed [CW-1:0] first_y;
    logic signed [CW-1:0] second_x;
    logic signed [CW-1:0] second_y;
    logic [RW-1:0]        other_radius;
  } in_t;

  typedef struct packed {
    logic                 hit;
    logic signed [CW-1:0] depth;
    logic                 point_valid;
    logic signed [CW-1:0] contact_x;
    logic signed [CW-1:0] contact_y;
  } out_t;

  typedef struct packed {
    logic          func;
    logic          proj_ok;
    logic          sx;
    logic          sy;
    logic [CW-1:0] cx;
    logic [CW-1:0] cy;
    logic [CW-1:0] ax;
    logic [CW-1:0] ay;
    logic [CW-1:0] bx;
    logic [CW-1:0] by;
    logic [CW-1:0] px;
    logic [CW-1:0] py;
    logic [RW-1:0] r;
    logic [RW-1:0] r2;
    logic [SW-1:0] sqa;
    logic [SW-1:0] sqb;
  } side_t;

  typedef struct packed {
    logic [SW-1:0] rem;
    logic [CW-1:0] nlo;
    logic [CW-1:0] q;
  } div_lane_t;

  typedef struct packed {
    logic                vld;
    side_t               side;
    logic [SW-1:0]       len2;
    div_lane_t [1:0]     lane;
  } div_stage_t;

  typedef struct packed {
    logic [REMW-1:0] rem;
    logic [SQW-1:0]  n;
    logic [RTW-1:0]  root;
  } sqrt_lane_t;

  typedef struct packed {
    logic             vld;
    side_t            side;
    sqrt_lane_t [2:0] lane;
  } sqrt_stage_t;

  function automatic logic [CW:0] sdiff(input logic [CW-1:0] a, input logic [CW-1:0] b);
    return {a[CW-1], a} - {b[CW-1], b};
  endfunction

  function automatic logic [CW-1:0] mag(input logic [CW:0] d);
    logic [CW:0] u;
    u = d;
    if (d[CW]) begin
      u = ~d + 1'b1;
    end
    return u[CW-1:0];
  endfunction

endpackage

`default_nettype wire

[sv/ccd_div_cell.sv]
// ----------------------------------------------------------------------------
// ccd_div_cell
// One restoring division step for the two projection quotients.
// ----------------------------------------------------------------------------
`default_nettype none

module ccd_div_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  ccd_pkg::div_stage_t d_in,
  output ccd_pkg::div_stage_t d_out
);
  import ccd_pkg::*;

  div_stage_t    st_nxt;
  div_stage_t    st_r;
  logic [SW:0]   sh [2];
  logic          ge [2];

  always_comb begin
    st_nxt = d_in;
    for (int i = 0; i < 2; i++) begin
      sh[i] = {d_in.lane[i].rem, d_in.lane[i].nlo[CW-1]};
      ge[i] = sh[i] >= {1'b0, d_in.len2};
      st_nxt.lane[i].rem = ge[i] ? SW'(sh[i] - {1'b0, d_in.len2}) : sh[i][SW-1:0];
      st_nxt.lane[i].nlo = {d_in.lane[i].nlo[CW-2:0], 1'b0};
      st_nxt.lane[i].q   = {d_in.lane[i].q[CW-2:0], ge[i]};
    end
  end

  always_ff @(posedge clk) begin
    st_r <= st_nxt;
    if (!rst_n) begin
      st_r.vld <= 1'b0;
    end
  end

  assign d_out = st_r;

endmodule

`default_nettype wire

[sv/ccd_sqrt_cell.sv]
// ----------------------------------------------------------------------------
// ccd_sqrt_cell
// One digit step of the integer square root for the three distance lanes.
// ----------------------------------------------------------------------------
`default_nettype none

module ccd_sqrt_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  ccd_pkg::sqrt_stage_t s_in,
  output ccd_pkg::sqrt_stage_t s_out
);
  import ccd_pkg::*;

  sqrt_stage_t     st_nxt;
  sqrt_stage_t     st_r;
  logic [REMW+1:0] sh    [3];
  logic [REMW+1:0] trial [3];
  logic            ge    [3];

  always_comb begin
    st_nxt = s_in;
    for (int i = 0; i < 3; i++) begin
      sh[i]    = {s_in.lane[i].rem, s_in.lane[i].n[SQW-1:SQW-2]};
      trial[i] = (REMW+2)'({s_in.lane[i].root, 2'b01});
      ge[i]    = sh[i] >= trial[i];
      st_nxt.lane[i].rem  = ge[i] ? REMW'(sh[i] - trial[i]) : REMW'(sh[i]);
      st_nxt.lane[i].root = {s_in.lane[i].root[RTW-2:0], ge[i]};
      st_nxt.lane[i].n    = {s_in.lane[i].n[SQW-3:0], 2'b00};
    end
  end

  always_ff @(posedge clk) begin
    st_r <= st_nxt;
    if (!rst_n) begin
      st_r.vld <= 1'b0;
    end
  end

  assign s_out = st_r;

endmodule

`default_nettype wire

[sv/ccd_front.sv]
// ----------------------------------------------------------------------------
// ccd_front
// Input capture, differences, squared distances, dot product and the
// projection numerators that feed the division chain.
// ----------------------------------------------------------------------------
`default_nettype none

module ccd_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_vld,
  input  ccd_pkg::in_t        in_data,
  output ccd_pkg::div_stage_t d_out
);
  import ccd_pkg::*;

  in_t           in_r;
  logic [5:0]    v_r;

  side_t         s2_r, s3_r, s4_r, s5_r, s6_r;
  logic [CW-1:0] emx_r, emy_r, fmx_r, fmy_r, dmx2_r, dmy2_r;
  logic          sex_r, sey_r, sdx_r, sdy_r;

  logic [PW-1:0] pex_r, pey_r, pfx_r, pfy_r, pdx_r, pdy_r, pt1_r, pt2_r;
  logic          t1n_r, t2n_r;
  logic [CW-1:0] dmx3_r, dmy3_r;

  logic [SW-1:0] len2_4_r, pos_r, neg_r;
  logic [CW-1:0] dmx4_r, dmy4_r;

  logic [SW-1:0] len2_5_r, dot_r;
  logic          ge_r;
  logic [CW-1:0] dmx5_r, dmy5_r;

  logic [SW-1:0] len2_6_r;
  logic [PW-1:0] xl_r, yl_r;
  logic [PW:0]   xh_r, yh_r;

  div_stage_t    d7_r;

  logic [CW:0]   ex, ey, fx, fy, dx, dy;
  logic [NW-1:0] nx, ny;

  assign ex = sdiff(in_r.center_x, in_r.first_x);
  assign ey = sdiff(in_r.center_y, in_r.first_y);
  assign fx = sdiff(in_r.center_x, in_r.second_x);
  assign fy = sdiff(in_r.center_y, in_r.second_y);
  assign dx = sdiff(in_r.second_x, in_r.first_x);
  assign dy = sdiff(in_r.second_y, in_r.first_y);

  assign nx = {xh_r, {CW{1'b0}}} + NW'(xl_r);
  assign ny = {yh_r, {CW{1'b0}}} + NW'(yl_r);

  always_ff @(posedge clk) begin
    v_r <= {v_r[4:0], in_vld};

    in_r <= in_data;

    s2_r         <= '0;
    s2_r.func    <= in_r.func;
    s2_r.sx      <= dx[CW];
    s2_r.sy      <= dy[CW];
    s2_r.cx      <= in_r.center_x;
    s2_r.cy      <= in_r.center_y;
    s2_r.ax      <= in_r.first_x;
    s2_r.ay      <= in_r.first_y;
    s2_r.bx      <= in_r.second_x;
    s2_r.by      <= in_r.second_y;
    s2_r.r       <= in_r.radius;
    s2_r.r2      <= in_r.other_radius;
    emx_r  <= mag(ex);
    emy_r  <= mag(ey);
    fmx_r  <= mag(fx);
    fmy_r  <= mag(fy);
    dmx2_r <= mag(dx);
    dmy2_r <= mag(dy);
    sex_r  <= ex[CW];
    sey_r  <= ey[CW];
    sdx_r  <= dx[CW];
    sdy_r  <= dy[CW];

    s3_r   <= s2_r;
    pex_r  <= PW'(emx_r) * PW'(emx_r);
    pey_r  <= PW'(emy_r) * PW'(emy_r);
    pfx_r  <= PW'(fmx_r) * PW'(fmx_r);
    pfy_r  <= PW'(fmy_r) * PW'(fmy_r);
    pdx_r  <= PW'(dmx2_r) * PW'(dmx2_r);
    pdy_r  <= PW'(dmy2_r) * PW'(dmy2_r);
    pt1_r  <= PW'(emx_r) * PW'(dmx2_r);
    pt2_r  <= PW'(emy_r) * PW'(dmy2_r);
    t1n_r  <= sex_r ^ sdx_r;
    t2n_r  <= sey_r ^ sdy_r;
    dmx3_r <= dmx2_r;
    dmy3_r <= dmy2_r;

    s4_r       <= s3_r;
    s4_r.sqa   <= SW'(pex_r) + SW'(pey_r);
    s4_r.sqb   <= SW'(pfx_r) + SW'(pfy_r);
    len2_4_r   <= SW'(pdx_r) + SW'(pdy_r);
    pos_r      <= (t1n_r ? '0 : SW'(pt1_r)) + (t2n_r ? '0 : SW'(pt2_r));
    neg_r      <= (t1n_r ? SW'(pt1_r) : '0) + (t2n_r ? SW'(pt2_r) : '0);
    dmx4_r     <= dmx3_r;
    dmy4_r     <= dmy3_r;

    s5_r     <= s4_r;
    dot_r    <= pos_r - neg_r;
    ge_r     <= pos_r >= neg_r;
    len2_5_r <= len2_4_r;
    dmx5_r   <= dmx4_r;
    dmy5_r   <= dmy4_r;

    s6_r         <= s5_r;
    s6_r.proj_ok <= ge_r && (len2_5_r != '0) && (dot_r <= len2_5_r);
    len2_6_r     <= len2_5_r;
    xl_r         <= PW'(dmx5_r) * PW'(dot_r[CW-1:0]);
    yl_r         <= PW'(dmy5_r) * PW'(dot_r[CW-1:0]);
    xh_r         <= (PW+1)'(dmx5_r) * (PW+1)'(dot_r[SW-1:CW]);
    yh_r         <= (PW+1)'(dmy5_r) * (PW+1)'(dot_r[SW-1:CW]);

    d7_r.vld         <= v_r[5];
    d7_r.side        <= s6_r;
    d7_r.len2        <= len2_6_r;
    d7_r.lane[0].rem <= nx[NW-1:CW];
    d7_r.lane[0].nlo <= nx[CW-1:0];
    d7_r.lane[0].q   <= '0;
    d7_r.lane[1].rem <= ny[NW-1:CW];
    d7_r.lane[1].nlo <= ny[CW-1:0];
    d7_r.lane[1].q   <= '0;

    if (!rst_n) begin
      v_r      <= '0;
      d7_r.vld <= 1'b0;
    end
  end

  assign d_out = d7_r;

endmodule

`default_nettype wire

[sv/ccd_mid.sv]
// ----------------------------------------------------------------------------
// ccd_mid
// Builds the projection point from the quotients and the squared distance
// from the center to it, then loads the square root chain.
// ----------------------------------------------------------------------------
`default_nettype none

module ccd_mid (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ccd_pkg::div_stage_t  d_in,
  output ccd_pkg::sqrt_stage_t s_out
);
  import ccd_pkg::*;

  logic [2:0]    v_r;
  side_t         s1_r, s2_r, s3_r;
  logic [CW-1:0] gmx_r, gmy_r;
  logic [PW-1:0] gx2_r, gy2_r;
  logic [CW:0]   gx, gy;

  assign gx = sdiff(s1_r.cx, s1_r.px);
  assign gy = sdiff(s1_r.cy, s1_r.py);

  always_ff @(posedge clk) begin
    v_r <= {v_r[1:0], d_in.vld};

    s1_r    <= d_in.side;
    s1_r.px <= d_in.side.sx ? d_in.side.ax - d_in.lane[0].q : d_in.side.ax + d_in.lane[0].q;
    s1_r.py <= d_in.side.sy ? d_in.side.ay - d_in.lane[1].q : d_in.side.ay + d_in.lane[1].q;

    s2_r  <= s1_r;
    gmx_r <= mag(gx);
    gmy_r <= mag(gy);

    s3_r  <= s2_r;
    gx2_r <= PW'(gmx_r) * PW'(gmx_r);
    gy2_r <= PW'(gmy_r) * PW'(gmy_r);

    if (!rst_n) begin
      v_r <= '0;
    end
  end

  always_comb begin
    s_out              = '0;
    s_out.vld          = v_r[2];
    s_out.side         = s3_r;
    s_out.lane[0].n    = SQW'(s3_r.sqa);
    s_out.lane[1].n    = SQW'(s3_r.sqb);
    s_out.lane[2].n    = SQW'(SW'(gx2_r) + SW'(gy2_r));
  end

endmodule

`default_nettype wire

[sv/circle_collision_depth_top.sv]
// ----------------------------------------------------------------------------
// circle_collision_depth_top
// Penetration depth of a circle against a segment or a second circle,
// computed in a fixed-latency pipeline of division and square root cells.
// ----------------------------------------------------------------------------
//  Channel   Ports                      Transfer
//  input     start, busy, in_data       start high while busy is low
//  result    out_valid, out_data        one-cycle strobe, always taken
//
//  One transaction is accepted every clock cycle; busy is held low.
//  Each result passes the front stages, the 32-step division chain, the
//  middle stages and the 33-step square root chain to the output register.
//  Results leave in acceptance order, one per transaction.
//  The synchronous reset clears the valid flags of every stage.
// ----------------------------------------------------------------------------
`default_nettype none

module circle_collision_depth_top (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  ccd_pkg::in_t  in_data,
  output logic          out_valid,
  output ccd_pkg::out_t out_data
);
  import ccd_pkg::*;

  div_stage_t      div_chain [CW+1];
  sqrt_stage_t     sq_chain  [RTW+1];
  sqrt_stage_t     fin;
  side_t           s;
  logic [RTW-1:0]  da, db, dd, m, rr;
  logic [RTW+1:0]  tc;
  logic [RTW+1-(CW-1):0] hib;
  logic            use_a;
  out_t            res_nxt;
  out_t            out_r;
  logic            vld_r;

  assign busy = 1'b0;

  ccd_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (start),
    .in_data (in_data),
    .d_out   (div_chain[0])
  );

  for (genvar i = 0; i < CW; i++) begin : g_div
    ccd_div_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .d_in  (div_chain[i]),
      .d_out (div_chain[i+1])
    );
  end

  ccd_mid u_mid (
    .clk   (clk),
    .rst_n (rst_n),
    .d_in  (div_chain[CW]),
    .s_out (sq_chain[0])
  );

  for (genvar i = 0; i < RTW; i++) begin : g_sqrt
    ccd_sqrt_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .s_in  (sq_chain[i]),
      .s_out (sq_chain[i+1])
    );
  end

  assign fin   = sq_chain[RTW];
  assign s     = fin.side;
  assign da    = fin.lane[0].root;
  assign db    = fin.lane[1].root;
  assign dd    = fin.lane[2].root;
  assign rr    = RTW'(s.r);
  assign use_a = da <= db;
  assign m     = use_a ? da : db;
  assign tc    = (RTW+2)'(s.r) + (RTW+2)'(s.r2) - (RTW+2)'(da);
  assign hib   = tc[RTW+1:CW-1];

  always_comb begin
    res_nxt = '0;
    if (s.func) begin
      res_nxt.hit = 1'b1;
      if (hib == '0 || hib == '1) begin
        res_nxt.depth = tc[CW-1:0];
      end else if (tc[RTW+1]) begin
        res_nxt.depth = {1'b1, {(CW-1){1'b0}}};
      end else begin
        res_nxt.depth = {1'b0, {(CW-1){1'b1}}};
      end
    end else if (s.proj_ok && dd <= rr) begin
      res_nxt.hit         = 1'b1;
      res_nxt.depth       = CW'(rr - dd);
      res_nxt.point_valid = 1'b1;
      res_nxt.contact_x   = s.px;
      res_nxt.contact_y   = s.py;
    end else if (m <= rr) begin
      res_nxt.hit         = 1'b1;
      res_nxt.depth       = CW'(rr - m);
      res_nxt.point_valid = 1'b1;
      res_nxt.contact_x   = use_a ? s.ax : s.bx;
      res_nxt.contact_y   = use_a ? s.ay : s.by;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= res_nxt;
    vld_r <= fin.vld;
    if (!rst_n) begin
      vld_r <= 1'b0;
    end
  end

  assign out_valid = vld_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

[tb/sv/tb_circle_collision_depth_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_circle_collision_depth_top
// Drives circle against segment and circle against circle queries into the
// collision depth pipeline and checks every result, field by field, against
// a wide-integer prediction of depth, hit flag and contact point.
// ----------------------------------------------------------------------------

module tb_circle_collision_depth_top;
  import ccd_pkg::*;

  localparam int NUM_RANDOM = 2000;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam logic FUNC_SEGMENT = 1'b0;
  localparam logic FUNC_CIRCLE = 1'b1;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_t in_data = '0;
  logic out_valid;
  out_t out_data;

  in_t pending_queries[$];
  out_t expected_contacts[$];
  int total_queries = 0;
  int sent_count = 0;
  int error_count = 0;
  int stall_cycles = 0;

  circle_collision_depth_top dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_data(in_data), .out_valid(out_valid), .out_data(out_data)
  );

  always #5 clk = ~clk;

  function automatic logic [127:0] sq_mag(longint a, longint b);
    logic [127:0] ma;
    logic [127:0] mb;
    ma = (a < 0) ? 128'(-a) : 128'(a);
    mb = (b < 0) ? 128'(-b) : 128'(b);
    return ma * ma + mb * mb;
  endfunction

  function automatic longint floor_sqrt(logic [127:0] n);
    logic [127:0] root;
    logic [127:0] trial;
    root = '0;
    for (int b = 40; b >= 0; b--) begin
      trial = root | (128'(1) << b);
      if (trial * trial <= n) root = trial;
    end
    return longint'(root);
  endfunction

  function automatic longint distance(longint x0, longint y0, longint x1, longint y1);
    return floor_sqrt(sq_mag(x1 - x0, y1 - y0));
  endfunction

  function automatic out_t predict_contact(in_t q);
    out_t res;
    longint cx, cy, ax, ay, bx, by, rad, rad2, d, da, db, m, px, py, dd;
    longint dx, dy;
    logic [127:0] len2, udot, qx, qy;
    logic signed [127:0] sdot, sex, sey, sdx, sdy;
    logic use_a;
    res = '0;
    cx = q.center_x; cy = q.center_y;
    ax = q.first_x; ay = q.first_y;
    bx = q.second_x; by = q.second_y;
    rad = longint'(q.radius); rad2 = longint'(q.other_radius);
    if (q.func == FUNC_CIRCLE) begin
      d = rad + rad2 - distance(cx, cy, ax, ay);
      if (d > 64'sd2147483647) d = 64'sd2147483647;
      if (d < -64'sd2147483648) d = -64'sd2147483648;
      res.hit = 1'b1;
      res.depth = d[31:0];
      return res;
    end
    dx = bx - ax; dy = by - ay;
    len2 = sq_mag(dx, dy);
    if (len2 != 0) begin
      sex = cx - ax; sey = cy - ay; sdx = dx; sdy = dy;
      sdot = sex * sdx + sey * sdy;
      if (sdot >= 0 && $unsigned(sdot) <= len2) begin
        udot = $unsigned(sdot);
        qx = (128'((dx < 0) ? -dx : dx) * udot) / len2;
        qy = (128'((dy < 0) ? -dy : dy) * udot) / len2;
        px = (dx < 0) ? ax - longint'(qx) : ax + longint'(qx);
        py = (dy < 0) ? ay - longint'(qy) : ay + longint'(qy);
        dd = distance(cx, cy, px, py);
        if (dd <= rad) begin
          res.hit = 1'b1;
          res.depth = 32'(rad - dd);
          res.point_valid = 1'b1;
          res.contact_x = px[31:0];
          res.contact_y = py[31:0];
          return res;
        end
      end
    end
    da = distance(cx, cy, ax, ay);
    db = distance(cx, cy, bx, by);
    use_a = (da <= db);
    m = use_a ? da : db;
    if (m <= rad) begin
      res.hit = 1'b1;
      res.depth = 32'(rad - m);
      res.point_valid = 1'b1;
      res.contact_x = use_a ? q.first_x : q.second_x;
      res.contact_y = use_a ? q.first_y : q.second_y;
    end
    return res;
  endfunction

  function automatic logic [31:0] window_coord(int shift);
    return $unsigned($signed($urandom()) >>> shift);
  endfunction

  function automatic in_t random_query();
    in_t q;
    int shift;
    int kind;
    q = '0;
    kind = $urandom_range(0, 99);
    shift = $urandom_range(1, 24);
    q.func = $urandom_range(0, 3) == 0 ? FUNC_CIRCLE : FUNC_SEGMENT;
    if (kind < 12) begin
      q.center_x = $urandom(); q.center_y = $urandom();
      q.first_x = $urandom(); q.first_y = $urandom();
      q.second_x = $urandom(); q.second_y = $urandom();
      q.radius = 31'($urandom()); q.other_radius = 31'($urandom());
    end else begin
      q.first_x = window_coord(shift); q.first_y = window_coord(shift);
      q.second_x = window_coord(shift); q.second_y = window_coord(shift);
      if (kind < 20) begin
        q.second_x = q.first_x; q.second_y = q.first_y;
      end
      q.center_x = q.first_x + window_coord(shift + 1);
      q.center_y = q.first_y + window_coord(shift + 1);
      if (kind < 60 && q.func == FUNC_SEGMENT) begin
        q.center_x = q.first_x + ((q.second_x - q.first_x) >>> 1) + window_coord(shift + 3);
        q.center_y = q.first_y + ((q.second_y - q.first_y) >>> 1) + window_coord(shift + 3);
      end
      q.radius = 31'($urandom() >> shift);
      q.other_radius = 31'($urandom() >> shift);
    end
    return q;
  endfunction

  function automatic in_t make_query(logic f, logic [31:0] cx, logic [31:0] cy,
      logic [30:0] r, logic [31:0] ax, logic [31:0] ay, logic [31:0] bx,
      logic [31:0] by, logic [30:0] r2);
    in_t q;
    q.func = f; q.center_x = cx; q.center_y = cy; q.radius = r;
    q.first_x = ax; q.first_y = ay; q.second_x = bx; q.second_y = by;
    q.other_radius = r2;
    return q;
  endfunction

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      error_count++;
      if (error_count <= 10)
        $display("Mismatch in %s: expected %h, got %h", name, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin
    int idle_pct;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        expected_contacts.push_back(predict_contact(in_data));
        sent_count++;
      end
      if (sent_count * 3 < total_queries) idle_pct = 24;
      else if (sent_count * 3 < total_queries * 2) idle_pct = 81;
      else idle_pct = 0;
      if (!(start && busy)) begin
        if (pending_queries.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
          start <= 1'b1;
          in_data <= pending_queries.pop_front();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    out_t exp_r;
    if (rst_n && out_valid) begin
      if (expected_contacts.size() == 0) begin
        error_count++;
        if (error_count <= 10) $display("Unexpected transaction on the result port");
      end else begin
        exp_r = expected_contacts.pop_front();
        check_field("hit", 32'(exp_r.hit), 32'(out_data.hit));
        check_field("depth", exp_r.depth, out_data.depth);
        check_field("point_valid", 32'(exp_r.point_valid), 32'(out_data.point_valid));
        check_field("contact_x", exp_r.contact_x, out_data.contact_x);
        check_field("contact_y", exp_r.contact_y, out_data.contact_y);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    pending_queries.push_back(make_query(FUNC_SEGMENT, 32'h7fffffff, 32'h7fffffff,
      31'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 31'h7fffffff));
    pending_queries.push_back(make_query(FUNC_SEGMENT, 32'h80000000, 32'h7fffffff,
      31'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000, 32'h80000000, 31'h0));
    pending_queries.push_back(make_query(FUNC_SEGMENT, 0, 32'h00010000, 31'h00020000,
      32'hfffb0000, 0, 32'h00050000, 0, 0));
    pending_queries.push_back(make_query(FUNC_SEGMENT, 32'h00080000, 32'h00010000,
      31'h00040000, 32'hfffb0000, 0, 32'h00050000, 0, 0));
    pending_queries.push_back(make_query(FUNC_SEGMENT, 32'h00080000, 0, 31'h00010000,
      32'hfffb0000, 0, 32'h00050000, 0, 0));
    pending_queries.push_back(make_query(FUNC_SEGMENT, 32'h00010000, 32'h00010000,
      31'h00020000, 32'h00020000, 32'h00020000, 32'h00020000, 32'h00020000, 0));
    pending_queries.push_back(make_query(FUNC_SEGMENT, 0, 32'h00010000, 31'h00030000,
      32'hffff0000, 0, 32'h00010000, 0, 0));
    pending_queries.push_back(make_query(FUNC_SEGMENT, 0, 32'h00030000, 31'h00030000,
      32'hffff0000, 0, 32'h00010000, 0, 0));
    pending_queries.push_back(make_query(FUNC_SEGMENT, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_queries.push_back(make_query(FUNC_SEGMENT, 32'h12345678, 32'h9abcdef0, 31'h100,
      0, 0, 32'h00010000, 32'h00010000, 0));
    pending_queries.push_back(make_query(FUNC_CIRCLE, 0, 0, 31'h7fffffff,
      0, 0, 0, 0, 31'h7fffffff));
    pending_queries.push_back(make_query(FUNC_CIRCLE, 32'h80000000, 32'h80000000, 0,
      32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 0));
    pending_queries.push_back(make_query(FUNC_CIRCLE, 0, 0, 31'h00010000,
      32'h00030000, 32'h00040000, 0, 0, 31'h00020000));
    pending_queries.push_back(make_query(FUNC_CIRCLE, 32'hffffffff, 32'hffffffff, 31'h1,
      32'h00000001, 32'h00000001, 32'hffffffff, 32'hffffffff, 31'h1));
    for (int i = 0; i < NUM_RANDOM; i++) pending_queries.push_back(random_query());
    total_queries = pending_queries.size();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    wait (pending_queries.size() == 0 && sent_count == total_queries);
    wait (expected_contacts.size() == 0);
    repeat (100) @(posedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
